// ----- sv/fba_pkg.sv -----
// fba_pkg: shared types and codes of the frame bitmap allocator
// used by fba_cell, fba_seq and frame_bitmap_allocator_unit; no dependencies
package fba_pkg;

    // request codes
    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    localparam logic [1:0] STRAT_LOWEST  = 2'd0;
    localparam logic [1:0] STRAT_WRAP    = 2'd1;
    localparam logic [1:0] STRAT_HIGHEST = 2'd2;

    // payload widths
    localparam int FRAME_W = 6;
    localparam int COUNT_W = 7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_RESP
    } state_t;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic               shift;
        logic               dir_down;
        logic               armed;
        logic               rel_en;
        logic [FRAME_W-1:0] rel_idx;
        logic               inject_lo;
        logic               inject_hi;
    } cell_ctrl_t;

endpackage

// ----- sv/fba_cell.sv -----
// fba_cell: one frame of the allocator ring, holds the in-use bit and the search token
// depends on fba_pkg
module fba_cell #(
    parameter int NUM_FRAMES = 64,
    parameter int INDEX      = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  fba_pkg::cell_ctrl_t ctrl,
    input  logic                tok_from_lo,
    input  logic                tok_from_hi,
    output logic                tok,
    output logic                used,
    output logic                hit,
    output logic                rel_hit
);

    localparam bit IS_FIRST = (INDEX == 0);
    localparam bit IS_LAST  = (INDEX == NUM_FRAMES - 1);

    logic used_reg, used_next;
    logic tok_reg, tok_next;
    logic rel_sel;
    logic inject_here;

    assign rel_sel     = ctrl.rel_en && (int'(ctrl.rel_idx) == INDEX);
    assign hit         = tok_reg && !used_reg && ctrl.armed;
    assign rel_hit     = rel_sel && used_reg;
    assign inject_here = (IS_FIRST && ctrl.inject_lo) || (IS_LAST && ctrl.inject_hi);

    always_comb begin
        used_next = used_reg;
        if (hit) begin
            used_next = 1'b1;
        end else if (rel_sel) begin
            used_next = 1'b0;
        end
        // token walks one cell per cycle in the chosen direction
        tok_next = inject_here
                 || (ctrl.shift && (ctrl.dir_down ? tok_from_hi : tok_from_lo));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= 1'b0;
            tok_reg  <= 1'b0;
        end else begin
            used_reg <= used_next;
            tok_reg  <= tok_next;
        end
    end

    assign tok  = tok_reg;
    assign used = used_reg;

endmodule

// ----- sv/fba_seq.sv -----
// fba_seq: request sequencer, search counters, free count and output register
// depends on fba_pkg; drives the cell ring of frame_bitmap_allocator_unit
module fba_seq #(
    parameter int NUM_FRAMES = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_mode,
    input  logic [1:0]                        s_strategy,
    input  logic [fba_pkg::FRAME_W-1:0]       s_start_index,
    input  logic [fba_pkg::FRAME_W-1:0]       s_release_frame,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [fba_pkg::FRAME_W-1:0]       m_frame_index,
    output logic                              m_granted,
    output logic [fba_pkg::COUNT_W-1:0]       m_free_count,
    input  logic                              hit_any,
    input  logic                              rel_hit_any,
    output fba_pkg::cell_ctrl_t               ctrl
);

    localparam int IW = $clog2(NUM_FRAMES);
    localparam int CW = $clog2(NUM_FRAMES + 1);
    localparam logic [IW-1:0] LAST = IW'(NUM_FRAMES - 1);

    fba_pkg::state_t state_reg, state_next;

    logic [fba_pkg::FRAME_W-1:0] skip_reg;
    logic [IW-1:0]               step_reg;
    logic [IW-1:0]               pos_reg;
    logic                        dir_down_reg;
    logic                        grant_reg;
    logic [CW-1:0]               free_cnt_reg;
    logic                        m_valid_reg;
    logic [fba_pkg::FRAME_W-1:0] m_frame_index_reg;
    logic                        m_granted_reg;
    logic [fba_pkg::COUNT_W-1:0] m_free_count_reg;

    logic accept, is_rel, strat_ok, armed, found, exhausted, shift, out_free;

    assign s_ready  = (state_reg == fba_pkg::ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign is_rel   = (s_mode == fba_pkg::MODE_RELEASE);
    assign strat_ok = (s_strategy == fba_pkg::STRAT_LOWEST)
                   || (s_strategy == fba_pkg::STRAT_WRAP)
                   || (s_strategy == fba_pkg::STRAT_HIGHEST);
    assign armed     = (state_reg == fba_pkg::ST_SEARCH) && (skip_reg == '0);
    assign found     = armed && hit_any;
    assign exhausted = armed && !hit_any && (step_reg == LAST);
    assign shift     = (state_reg == fba_pkg::ST_SEARCH) && !found && !exhausted;
    assign out_free  = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fba_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = (!is_rel && strat_ok) ? fba_pkg::ST_SEARCH
                                                       : fba_pkg::ST_RESP;
                end
            end
            fba_pkg::ST_SEARCH: begin
                if (found || exhausted) begin
                    state_next = fba_pkg::ST_RESP;
                end
            end
            fba_pkg::ST_RESP: begin
                if (out_free) begin
                    state_next = fba_pkg::ST_IDLE;
                end
            end
            default: state_next = fba_pkg::ST_IDLE;
        endcase
    end

    // ring control
    always_comb begin
        ctrl.shift     = shift;
        ctrl.dir_down  = dir_down_reg;
        ctrl.armed     = armed;
        ctrl.rel_en    = accept && is_rel;
        ctrl.rel_idx   = s_release_frame;
        ctrl.inject_lo = accept && !is_rel
                      && ((s_strategy == fba_pkg::STRAT_LOWEST)
                       || (s_strategy == fba_pkg::STRAT_WRAP));
        ctrl.inject_hi = accept && !is_rel && (s_strategy == fba_pkg::STRAT_HIGHEST);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= fba_pkg::ST_IDLE;
            free_cnt_reg <= CW'(NUM_FRAMES);
            grant_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (accept) begin
                grant_reg    <= 1'b0;
                dir_down_reg <= (s_strategy == fba_pkg::STRAT_HIGHEST);
                skip_reg     <= (s_strategy == fba_pkg::STRAT_WRAP) ? s_start_index : '0;
                step_reg     <= '0;
                pos_reg      <= (s_strategy == fba_pkg::STRAT_HIGHEST) ? LAST : '0;
                if (is_rel && rel_hit_any) begin
                    free_cnt_reg <= free_cnt_reg + 1'b1;
                end
            end

            if (shift) begin
                if (dir_down_reg) begin
                    pos_reg <= (pos_reg == '0) ? LAST : pos_reg - 1'b1;
                end else begin
                    pos_reg <= (pos_reg == LAST) ? '0 : pos_reg + 1'b1;
                end
                if (skip_reg != '0) begin
                    skip_reg <= skip_reg - 1'b1;
                end else begin
                    step_reg <= step_reg + 1'b1;
                end
            end

            if (found) begin
                grant_reg    <= 1'b1;
                free_cnt_reg <= free_cnt_reg - 1'b1;
            end

            if (state_reg == fba_pkg::ST_RESP && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (state_reg == fba_pkg::ST_RESP && out_free) begin
            m_frame_index_reg <= grant_reg ? fba_pkg::FRAME_W'(pos_reg) : '0;
            m_granted_reg     <= grant_reg;
            m_free_count_reg  <= fba_pkg::COUNT_W'(free_cnt_reg);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_frame_index = m_frame_index_reg;
    assign m_granted     = m_granted_reg;
    assign m_free_count  = m_free_count_reg;

endmodule

// ----- sv/frame_bitmap_allocator_unit.sv -----
// frame_bitmap_allocator_unit: top level, ring of frame cells plus request sequencer
// depends on fba_pkg, fba_cell, fba_seq
//
//   channel | direction | beat contents
//   --------+-----------+------------------------------------------------------
//   s_      | in        | s_mode, s_strategy, s_start_index, s_release_frame
//   m_      | out       | m_frame_index, m_granted, m_free_count
//
// flow: one beat at a time; a release or an unused strategy code goes from accept straight
//   to the response state, an allocation first walks k token hops (start_index skip hops plus
//   search hops, at most start_index + NUM_FRAMES - 1); s_ready returns with m_valid, so a
//   new beat is taken only once the result of the last one is in the output register
// reset: aresetn synchronous active low, all frames free, free count = NUM_FRAMES
// stalls: a result held by m_ready keeps the block in its response state; the next
//   beat is taken once the result has moved into the output register
module frame_bitmap_allocator_unit #(
    parameter int NUM_FRAMES = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_mode,
    input  logic [1:0]                  s_strategy,
    input  logic [fba_pkg::FRAME_W-1:0] s_start_index,
    input  logic [fba_pkg::FRAME_W-1:0] s_release_frame,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [fba_pkg::FRAME_W-1:0] m_frame_index,
    output logic                        m_granted,
    output logic [fba_pkg::COUNT_W-1:0] m_free_count
);

    fba_pkg::cell_ctrl_t ctrl;

    // per-frame views of the ring
    logic [NUM_FRAMES-1:0] tok_vec;
    logic [NUM_FRAMES-1:0] used_vec;
    logic [NUM_FRAMES-1:0] hit_vec;
    logic [NUM_FRAMES-1:0] rel_hit_vec;

    logic hit_any;
    logic rel_hit_any;

    // a free cell holding the armed token claims itself
    assign hit_any     = |hit_vec;
    // a release only bumps the free count when the frame was really in use
    assign rel_hit_any = |rel_hit_vec;

    // the cells form a closed ring so the wrap search needs no special path
    for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
        localparam int LO = (i == 0) ? NUM_FRAMES - 1 : i - 1;
        localparam int HI = (i == NUM_FRAMES - 1) ? 0 : i + 1;

        fba_cell #(
            .NUM_FRAMES (NUM_FRAMES),
            .INDEX      (i)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .tok_from_lo (tok_vec[LO]),
            .tok_from_hi (tok_vec[HI]),
            .tok         (tok_vec[i]),
            .used        (used_vec[i]),
            .hit         (hit_vec[i]),
            .rel_hit     (rel_hit_vec[i])
        );
    end

    // sequencer: accepts beats, counts skip and search hops, tracks the token
    // position, keeps the free count and owns the output register
    fba_seq #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_seq (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_strategy      (s_strategy),
        .s_start_index   (s_start_index),
        .s_release_frame (s_release_frame),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_index   (m_frame_index),
        .m_granted       (m_granted),
        .m_free_count    (m_free_count),
        .hit_any         (hit_any),
        .rel_hit_any     (rel_hit_any),
        .ctrl            (ctrl)
    );

    // at most one search token lives in the ring
    a_tok_single: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(tok_vec))
        else $error("more than one search token in the ring");

    // no token is left behind once the block waits for a new beat
    a_tok_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (tok_vec == '0))
        else $error("search token present while idle");

    // a claimed frame is marked in use on the following edge
    a_claim_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        (hit_vec != '0) |=> ((used_vec & $past(hit_vec)) == $past(hit_vec)))
        else $error("claimed frame not marked in use");

    // a granted result never reports every frame as free
    a_grant_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_granted) |-> (int'(m_free_count) < NUM_FRAMES))
        else $error("grant reported with all frames free");

endmodule

// ----- bench/tb_frame_bitmap_allocator_unit.sv -----
`timescale 1ns / 100ps
// tb_frame_bitmap_allocator_unit: self-checking bench for the frame bitmap allocator
// depends on fba_pkg and frame_bitmap_allocator_unit; predicts every result in-bench
// from a private copy of the in-use bitmap
module tb_frame_bitmap_allocator_unit;

    localparam int NUM_FRAMES    = 64;
    localparam int NO_FRAME      = -1;
    localparam logic [1:0] STRAT_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS  = 1350;
    // worst allocation walks start_index skip hops plus a full ring, plus slack
    localparam int DRAIN_CYCLES  = 2 + 2 * NUM_FRAMES + 16;
    // ~1400 beats at their worst-case length each, taken several times over
    localparam int CYCLE_LIMIT   = 1000000;

    typedef struct packed {
        logic                        mode;
        logic [1:0]                  strategy;
        logic [fba_pkg::FRAME_W-1:0] start;
        logic [fba_pkg::FRAME_W-1:0] rel;
    } frame_req_t;

    typedef struct packed {
        logic [fba_pkg::FRAME_W-1:0] frame;
        logic                        granted;
        logic [fba_pkg::COUNT_W-1:0] free;
    } frame_res_t;

    // clock, reset and dut ports; every input is known from time zero
    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic                        s_mode = fba_pkg::MODE_ALLOC;
    logic [1:0]                  s_strategy = fba_pkg::STRAT_LOWEST;
    logic [fba_pkg::FRAME_W-1:0] s_start_index = '0;
    logic [fba_pkg::FRAME_W-1:0] s_release_frame = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [fba_pkg::FRAME_W-1:0] m_frame_index;
    logic                        m_granted;
    logic [fba_pkg::COUNT_W-1:0] m_free_count;

    // requests waiting for the driver, and results owed by the dut
    frame_req_t pending_requests[$];
    frame_res_t predicted_results[$];

    // plan_map tracks the bitmap as stimulus is generated (to aim releases);
    // model_map is the predictor's bitmap, advanced only on accepted beats
    logic [NUM_FRAMES-1:0] plan_map;
    logic [NUM_FRAMES-1:0] model_map;

    // driver and monitor state
    frame_req_t cur_req;
    frame_res_t owed;
    logic       drv_busy;
    logic       mon_ready;
    int         gap_left;
    int         stall_left;
    logic       sender_gaps_on;
    logic       receiver_gaps_on;

    // bookkeeping
    int errors;
    int cycle_count;
    int n_grants;
    int n_refusals;
    int n_releases;
    int n_unused;
    int n_full_refusals;

    frame_bitmap_allocator_unit #(
        .NUM_FRAMES(NUM_FRAMES)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_strategy     (s_strategy),
        .s_start_index  (s_start_index),
        .s_release_frame(s_release_frame),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_index  (m_frame_index),
        .m_granted      (m_granted),
        .m_free_count   (m_free_count)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // applies one request to a bitmap and returns the result it produces:
    // release clears the bit, allocation searches per strategy and marks the hit,
    // the unused strategy code and a full map leave the bitmap alone
    function automatic frame_res_t apply_request(inout logic [NUM_FRAMES-1:0] in_use,
                                                 input frame_req_t req);
        frame_res_t res;
        int pick;
        int idx;
        int k;
        res = '0;
        pick = NO_FRAME;
        if (req.mode == fba_pkg::MODE_RELEASE) begin
            if (int'(req.rel) < NUM_FRAMES) begin
                in_use[req.rel] = 1'b0;
            end
        end else begin
            case (req.strategy)
                fba_pkg::STRAT_LOWEST: begin
                    for (k = 0; k < NUM_FRAMES; k++) begin
                        if (pick == NO_FRAME && !in_use[k]) pick = k;
                    end
                end
                fba_pkg::STRAT_WRAP: begin
                    // start taken modulo the frame count, fails only after a full lap
                    for (k = 0; k < NUM_FRAMES; k++) begin
                        idx = (int'(req.start) % NUM_FRAMES + k) % NUM_FRAMES;
                        if (pick == NO_FRAME && !in_use[idx]) pick = idx;
                    end
                end
                fba_pkg::STRAT_HIGHEST: begin
                    for (k = NUM_FRAMES - 1; k >= 0; k--) begin
                        if (pick == NO_FRAME && !in_use[k]) pick = k;
                    end
                end
                default: begin
                    // unused code: request ignored
                end
            endcase
            if (pick != NO_FRAME) begin
                in_use[pick] = 1'b1;
                res.frame = fba_pkg::FRAME_W'(pick);
                res.granted = 1'b1;
            end
        end
        res.free = fba_pkg::COUNT_W'(NUM_FRAMES - $countones(in_use));
        return res;
    endfunction

    // queue a request and keep the planning bitmap in step with it
    function automatic void queue_request(input logic mode, input logic [1:0] strategy,
                                          input int start, input int rel);
        frame_req_t req;
        frame_res_t unused_res;
        req.mode = mode;
        req.strategy = strategy;
        req.start = fba_pkg::FRAME_W'(start);
        req.rel = fba_pkg::FRAME_W'(rel);
        unused_res = apply_request(plan_map, req);
        pending_requests.push_back(req);
    endfunction

    // random request; alloc_pct steers the fill level of the map. releases
    // mostly target a frame in use so the map can empty again
    function automatic bit draw_request(input int alloc_pct);
        logic               mode;
        logic [1:0]         strategy;
        int                 rel;
        int                 k;
        int                 probe;
        bit                 aimed;
        mode = ($urandom_range(99) < alloc_pct) ? fba_pkg::MODE_ALLOC
                                                : fba_pkg::MODE_RELEASE;
        if ($urandom_range(19) == 0) begin
            strategy = STRAT_UNUSED;
        end else begin
            strategy = 2'($urandom_range(int'(fba_pkg::STRAT_HIGHEST)));
        end
        rel = $urandom_range(NUM_FRAMES - 1);
        aimed = 1'b0;
        if (mode == fba_pkg::MODE_RELEASE && $urandom_range(9) < 8) begin
            for (k = 0; k < NUM_FRAMES; k++) begin
                probe = (rel + k) % NUM_FRAMES;
                if (!aimed && plan_map[probe]) begin
                    rel = probe;
                    aimed = 1'b1;
                end
            end
        end
        queue_request(mode, strategy, $urandom_range(63), rel);
        // ignored requests don't count toward the random total
        return !(mode == fba_pkg::MODE_ALLOC && strategy == STRAT_UNUSED);
    endfunction

    // driver: presents queued requests, predicts the result of each accepted beat,
    // then, while sender gaps are on, waits a drawn number of idle cycles before the next one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left = 0;
        end else begin
            drv_busy = s_valid;
            if (s_valid && s_ready) begin
                predicted_results.push_back(apply_request(model_map, cur_req));
                if (cur_req.mode == fba_pkg::MODE_RELEASE) begin
                    n_releases++;
                end else if (cur_req.strategy == STRAT_UNUSED) begin
                    n_unused++;
                end else if (predicted_results[$].granted) begin
                    n_grants++;
                end else begin
                    n_refusals++;
                    if (model_map == '1) n_full_refusals++;
                end
                drv_busy = 1'b0;
                gap_left = sender_gaps_on ? $urandom_range(3) : 0;
            end else if (!drv_busy && gap_left > 0) begin
                gap_left--;
            end
            if (!drv_busy && gap_left == 0 && pending_requests.size() > 0) begin
                cur_req = pending_requests.pop_front();
                drv_busy = 1'b1;
                s_mode <= cur_req.mode;
                s_strategy <= cur_req.strategy;
                s_start_index <= cur_req.start;
                s_release_frame <= cur_req.rel;
            end
            s_valid <= drv_busy;
        end
    end

    // monitor: checks each result beat against the oldest prediction and, while
    // receiver gaps are on, drops ready for a drawn number of cycles after every beat
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            mon_ready = m_ready;
            if (m_valid && m_ready) begin
                if (predicted_results.size() == 0) begin
                    errors++;
                    $display("%0t: result beat with nothing expected: %s %0d %0b %0d",
                             $time, "frame/granted/free", m_frame_index, m_granted,
                             m_free_count);
                end else begin
                    owed = predicted_results.pop_front();
                    if (m_frame_index !== owed.frame) begin
                        errors++;
                        $display("%0t: frame_index expected %0d, actual %0d",
                                 $time, owed.frame, m_frame_index);
                    end
                    if (m_granted !== owed.granted) begin
                        errors++;
                        $display("%0t: granted expected %0b, actual %0b",
                                 $time, owed.granted, m_granted);
                    end
                    if (m_free_count !== owed.free) begin
                        errors++;
                        $display("%0t: free_count expected %0d, actual %0d",
                                 $time, owed.free, m_free_count);
                    end
                end
                stall_left = receiver_gaps_on ? $urandom_range(3) : 0;
                mon_ready = (stall_left == 0);
            end else if (!mon_ready) begin
                if (stall_left > 0) stall_left--;
                if (stall_left == 0) mon_ready = 1'b1;
            end
            m_ready <= mon_ready;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, predicted_results.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // stimulus sequencing and end of run
    initial begin
        int random_done;
        int phase;
        int len;
        int alloc_pct;
        int n;
        errors = 0;
        cycle_count = 0;
        n_grants = 0;
        n_refusals = 0;
        n_releases = 0;
        n_unused = 0;
        n_full_refusals = 0;
        plan_map = '0;
        model_map = '0;
        sender_gaps_on = 1'b1;
        receiver_gaps_on = 1'b1;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part: extremes, every strategy, wrap past the top, unused code,
        // release of a free frame
        @(negedge aclk);
        queue_request(fba_pkg::MODE_ALLOC, fba_pkg::STRAT_LOWEST, 0, 0);     // frame 0
        queue_request(fba_pkg::MODE_ALLOC, fba_pkg::STRAT_HIGHEST, 0, 0);    // frame 63
        queue_request(fba_pkg::MODE_ALLOC, fba_pkg::STRAT_WRAP, 63, 0);      // past 63, 0 to 1
        queue_request(fba_pkg::MODE_ALLOC, fba_pkg::STRAT_WRAP, 0, 63);      // skips 0, 1, gets 2
        queue_request(fba_pkg::MODE_ALLOC, fba_pkg::STRAT_WRAP, 37, 21);     // free start
        queue_request(fba_pkg::MODE_ALLOC, STRAT_UNUSED, 63, 63);            // ignored
        queue_request(fba_pkg::MODE_RELEASE, fba_pkg::STRAT_LOWEST, 0, 63);
        queue_request(fba_pkg::MODE_RELEASE, fba_pkg::STRAT_HIGHEST, 42, 63); // already free
        queue_request(fba_pkg::MODE_RELEASE, STRAT_UNUSED, 63, 0);  // release ignores strategy
        queue_request(fba_pkg::MODE_ALLOC, fba_pkg::STRAT_LOWEST, 63, 63);   // frame 0 again
        queue_request(fba_pkg::MODE_ALLOC, fba_pkg::STRAT_HIGHEST, 63, 0);   // frame 63 again
        queue_request(fba_pkg::MODE_RELEASE, fba_pkg::STRAT_WRAP, 0, 37);
        queue_request(fba_pkg::MODE_ALLOC, fba_pkg::STRAT_WRAP, 38, 0);      // start is free
        queue_request(fba_pkg::MODE_ALLOC, fba_pkg::STRAT_WRAP, 36, 0);      // 36, 37 stays free
        queue_request(fba_pkg::MODE_ALLOC, fba_pkg::STRAT_WRAP, 36, 0);      // skips 36, gets 37
        queue_request(fba_pkg::MODE_RELEASE, fba_pkg::STRAT_LOWEST, 0, 1);
        queue_request(fba_pkg::MODE_RELEASE, fba_pkg::STRAT_LOWEST, 0, 2);
        queue_request(fba_pkg::MODE_RELEASE, fba_pkg::STRAT_LOWEST, 0, 0);
        queue_request(fba_pkg::MODE_ALLOC, fba_pkg::STRAT_LOWEST, 0, 0);     // lowest is 0 again

        // random part in phases: filling phases drive the map full (refusals,
        // wrap hits behind start), draining phases empty it, mixed ones wander
        random_done = 0;
        phase = 0;
        while (random_done < RANDOM_ITEMS) begin
            do @(negedge aclk); while (pending_requests.size() > 0);
            // every fourth phase the sender holds off until the dut is fully drained
            if (phase % 4 == 3) begin
                do @(negedge aclk);
                while (s_valid || predicted_results.size() > 0);
            end
            case ($urandom_range(2))
                0: alloc_pct = 90;
                1: alloc_pct = 15;
                default: alloc_pct = 50;
            endcase
            // some phases run back-to-back on one or both sides
            sender_gaps_on = ($urandom_range(3) != 0);
            receiver_gaps_on = ($urandom_range(3) != 0);
            len = $urandom_range(40, 120);
            n = 0;
            while (n < len) begin
                if (draw_request(alloc_pct)) n++;
            end
            random_done += len;
            phase++;
        end

        // all stimulus accepted, then every result in, then a quiet tail
        do @(negedge aclk); while (pending_requests.size() > 0 || s_valid);
        do @(negedge aclk); while (predicted_results.size() > 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("covered %0d grants, %0d refusals (%0d on a full map), %0d releases,",
                 n_grants, n_refusals, n_full_refusals, n_releases);
        $display("%0d unused-strategy requests over %0d random phases",
                 n_unused, phase);
        if (errors == 0 && predicted_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/fba_pkg.sv
sv/fba_cell.sv
sv/fba_seq.sv
sv/frame_bitmap_allocator_unit.sv
bench/tb_frame_bitmap_allocator_unit.sv
